### rtl/bsf_pkg.sv
// Shared types, constants and command encodings for the balance state-feedback block.
`default_nettype none

package bsf_pkg;

    localparam int IN_W      = 16;
    localparam int GAIN_W    = 32;
    localparam int LIMIT_W   = 31;
    localparam int INTEG_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int MUL_W     = 33;
    localparam int ACC_W     = 64;

    localparam logic [GAIN_W-1:0] OUT_SCALE_RESET = 32'h0001_0000;
    localparam logic signed [ACC_W-1:0] TORQUE_MAX = 64'sd32767;
    localparam logic signed [ACC_W-1:0] TORQUE_MIN = -64'sd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_PITCH      = 3'd0,
        CFG_GAIN_PITCH_RATE = 3'd1,
        CFG_GAIN_SPEED      = 3'd2,
        CFG_GAIN_POSITION   = 3'd3,
        CFG_INTEGRAL_LIMIT  = 3'd4,
        CFG_OUT_SCALE       = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_pitch;
        logic signed [GAIN_W-1:0] gain_pitch_rate;
        logic signed [GAIN_W-1:0] gain_speed;
        logic signed [GAIN_W-1:0] gain_position;
        logic [LIMIT_W-1:0]       integral_limit;
        logic signed [GAIN_W-1:0] out_scale;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INC,
        S_INTEG,
        S_RATE,
        S_SPEED,
        S_POS,
        S_POS_ACC,
        S_SCALE_LO,
        S_SCALE_HI,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_SPEED_PERIOD,
        MUL_PITCH,
        MUL_RATE,
        MUL_SPEED,
        MUL_POS,
        MUL_SCALE_LO,
        MUL_SCALE_HI
    } t_mul_sel;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_ADD_SHR4,
        ACC_LOAD_SHR32
    } t_acc_op;

    typedef struct packed {
        logic     in_load;
        logic     integ_clear;
        logic     integ_load;
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_status;

endpackage

`default_nettype wire

### rtl/bsf_cfg_regs.sv
// Configuration register file: gains, integral limit and output scale.
`default_nettype none

module bsf_cfg_regs
    import bsf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wen,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_pitch      <= '0;
            r_cfg.gain_pitch_rate <= '0;
            r_cfg.gain_speed      <= '0;
            r_cfg.gain_position   <= '0;
            r_cfg.integral_limit  <= '0;
            r_cfg.out_scale       <= OUT_SCALE_RESET;
        end else if (i_cfg_wen) begin
            case (i_cfg_index)
                CFG_GAIN_PITCH:      r_cfg.gain_pitch      <= i_cfg_data;
                CFG_GAIN_PITCH_RATE: r_cfg.gain_pitch_rate <= i_cfg_data;
                CFG_GAIN_SPEED:      r_cfg.gain_speed      <= i_cfg_data;
                CFG_GAIN_POSITION:   r_cfg.gain_position   <= i_cfg_data;
                CFG_INTEGRAL_LIMIT:  r_cfg.integral_limit  <= i_cfg_data[LIMIT_W-1:0];
                CFG_OUT_SCALE:       r_cfg.out_scale       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### rtl/bsf_ctrl.sv
// Controller state machine sequencing the shared multiplier and accumulator.
`default_nettype none

module bsf_ctrl
    import bsf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_in_kind,
    input  wire logic i_out_stall,
    input  t_status   i_status,
    output logic      o_in_stall,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_out_free;

    assign w_out_free = !i_status.out_full || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !i_in_kind) begin
                    n_state = S_INC;
                end
            end
            S_INC:      n_state = S_INTEG;
            S_INTEG:    n_state = S_RATE;
            S_RATE:     n_state = S_SPEED;
            S_SPEED:    n_state = S_POS;
            S_POS:      n_state = S_POS_ACC;
            S_POS_ACC:  n_state = S_SCALE_LO;
            S_SCALE_LO: n_state = S_SCALE_HI;
            S_SCALE_HI: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '{in_load: 1'b0, integ_clear: 1'b0, integ_load: 1'b0,
                       mul_sel: MUL_NONE, acc_op: ACC_HOLD, out_load: 1'b0};
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall        = !i_rst_n;
                o_cmd.in_load     = i_in_valid && !i_in_kind;
                o_cmd.integ_clear = i_in_valid && i_in_kind;
            end
            S_INC: begin
                o_cmd.mul_sel = MUL_SPEED_PERIOD;
            end
            S_INTEG: begin
                o_cmd.integ_load = 1'b1;
                o_cmd.mul_sel    = MUL_PITCH;
            end
            S_RATE: begin
                o_cmd.acc_op  = ACC_LOAD;
                o_cmd.mul_sel = MUL_RATE;
            end
            S_SPEED: begin
                o_cmd.acc_op  = ACC_ADD;
                o_cmd.mul_sel = MUL_SPEED;
            end
            S_POS: begin
                o_cmd.acc_op  = ACC_ADD;
                o_cmd.mul_sel = MUL_POS;
            end
            S_POS_ACC: begin
                o_cmd.acc_op = ACC_ADD_SHR4;
            end
            S_SCALE_LO: begin
                o_cmd.mul_sel = MUL_SCALE_LO;
            end
            S_SCALE_HI: begin
                o_cmd.mul_sel = MUL_SCALE_HI;
                o_cmd.acc_op  = ACC_LOAD_SHR32;
            end
            S_DONE: begin
                o_cmd.out_load = w_out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/bsf_datapath.sv
// Datapath: input capture, integral state, shared multiplier, accumulator, output register.
`default_nettype none

module bsf_datapath
    import bsf_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  t_cmd                          i_cmd,
    input  t_cfg                          i_cfg,
    input  wire logic signed [IN_W-1:0]   i_pitch,
    input  wire logic signed [IN_W-1:0]   i_pitch_rate,
    input  wire logic signed [IN_W-1:0]   i_wheel_speed,
    input  wire logic [IN_W-1:0]          i_period,
    input  wire logic                     i_out_stall,
    output t_status                       o_status,
    output logic                          o_out_valid,
    output logic signed [IN_W-1:0]        o_torque
);

    logic signed [IN_W-1:0]      r_pitch;
    logic signed [IN_W-1:0]      r_rate;
    logic signed [IN_W-1:0]      r_speed;
    logic [IN_W-1:0]             r_period;
    logic signed [INTEG_W-1:0]   r_integ;
    logic signed [ACC_W-1:0]     r_prod;
    logic signed [ACC_W-1:0]     r_acc;
    logic                        r_out_valid;
    logic signed [IN_W-1:0]      r_torque;

    logic signed [MUL_W-1:0]     w_mul_a;
    logic signed [MUL_W-1:0]     w_mul_b;
    logic signed [2*MUL_W-1:0]   w_mul_p;
    logic signed [INTEG_W:0]     w_dec;
    logic signed [INTEG_W:0]     w_integ_raw;
    logic signed [INTEG_W:0]     w_lim;
    logic signed [INTEG_W:0]     w_lim_neg;
    logic signed [INTEG_W:0]     w_integ_clamp;
    logic signed [ACC_W-1:0]     w_total;
    logic signed [IN_W-1:0]      w_sat;

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_pitch  <= i_pitch;
            r_rate   <= i_pitch_rate;
            r_speed  <= i_wheel_speed;
            r_period <= i_period;
        end
    end

    // integral update: subtract floor(speed * period / 2^12), clamp to +/- limit
    assign w_dec       = r_prod[INTEG_W+12:12];
    assign w_integ_raw = {r_integ[INTEG_W-1], r_integ} - w_dec;
    assign w_lim       = {2'b00, i_cfg.integral_limit};
    assign w_lim_neg   = -w_lim;

    always_comb begin
        if (w_integ_raw > w_lim) begin
            w_integ_clamp = w_lim;
        end else if (w_integ_raw < w_lim_neg) begin
            w_integ_clamp = w_lim_neg;
        end else begin
            w_integ_clamp = w_integ_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
        end else if (i_cmd.integ_clear) begin
            r_integ <= '0;
        end else if (i_cmd.integ_load) begin
            r_integ <= w_integ_clamp[INTEG_W-1:0];
        end
    end

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_cmd.mul_sel)
            MUL_SPEED_PERIOD: begin
                w_mul_a = MUL_W'(r_speed);
                w_mul_b = {{(MUL_W-IN_W){1'b0}}, r_period};
            end
            MUL_PITCH: begin
                w_mul_a = MUL_W'(i_cfg.gain_pitch);
                w_mul_b = MUL_W'(r_pitch);
            end
            MUL_RATE: begin
                w_mul_a = MUL_W'(i_cfg.gain_pitch_rate);
                w_mul_b = MUL_W'(r_rate);
            end
            MUL_SPEED: begin
                w_mul_a = MUL_W'(i_cfg.gain_speed);
                w_mul_b = MUL_W'(r_speed);
            end
            MUL_POS: begin
                w_mul_a = MUL_W'(i_cfg.gain_position);
                w_mul_b = MUL_W'(r_integ);
            end
            MUL_SCALE_LO: begin
                w_mul_a = {1'b0, r_acc[ACC_W/2-1:0]};
                w_mul_b = MUL_W'(i_cfg.out_scale);
            end
            MUL_SCALE_HI: begin
                w_mul_a = MUL_W'($signed(r_acc[ACC_W-1:ACC_W/2]));
                w_mul_b = MUL_W'(i_cfg.out_scale);
            end
            default: begin
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_sel != MUL_NONE) begin
            r_prod <= w_mul_p[ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.acc_op)
            ACC_LOAD:       r_acc <= r_prod;
            ACC_ADD:        r_acc <= r_acc + r_prod;
            ACC_ADD_SHR4:   r_acc <= r_acc + (r_prod >>> 4);
            ACC_LOAD_SHR32: r_acc <= r_prod >>> 32;
            default: begin
            end
        endcase
    end

    // final: high half times scale plus floored low-half contribution, then saturate
    assign w_total = r_acc + r_prod;

    always_comb begin
        if (w_total > TORQUE_MAX) begin
            w_sat = TORQUE_MAX[IN_W-1:0];
        end else if (w_total < TORQUE_MIN) begin
            w_sat = TORQUE_MIN[IN_W-1:0];
        end else begin
            w_sat = w_total[IN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_torque <= w_sat;
        end
    end

    assign o_status.out_full = r_out_valid;
    assign o_out_valid       = r_out_valid;
    assign o_torque          = r_torque;

endmodule

`default_nettype wire

### rtl/balance_state_feedback.sv
// Top level of the balance state-feedback controller with speed integral.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+--------------------------------------
//  in        | input     | i_in_valid / o_in_stall    | kind, pitch, pitch_rate, wheel_speed,
//            |           |                            | period
//  out       | output    | o_out_valid / i_out_stall  | torque
//  cfg       | input     | i_cfg_wen                  | i_cfg_index, i_cfg_data
//
//  A control request goes from acceptance through S_INC to S_SCALE_HI into S_DONE,
//  which loads the result: seven passes through the one shared 33x33 multiplier
//  plus accumulate and final saturate steps; no new request is taken before S_IDLE.
//  A clear request zeroes the integral in S_IDLE and gives no result.
//  Reset clears the integral and the gains, and sets the output scale to 1.0.
//  A result stalled at the output holds the next control request in its last step.
`default_nettype none

module balance_state_feedback
    import bsf_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic                   i_in_kind,
    input  wire logic signed [IN_W-1:0] i_in_pitch,
    input  wire logic signed [IN_W-1:0] i_in_pitch_rate,
    input  wire logic signed [IN_W-1:0] i_in_wheel_speed,
    input  wire logic [IN_W-1:0]        i_in_period,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic signed [IN_W-1:0]      o_out_torque,
    input  wire logic                   i_cfg_wen,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0]   i_cfg_data
);

    t_cfg    w_cfg;
    t_cmd    w_cmd;
    t_status w_status;

    bsf_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    bsf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_kind   (i_in_kind),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_in_stall  (o_in_stall),
        .o_cmd       (w_cmd)
    );

    bsf_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_cfg         (w_cfg),
        .i_pitch       (i_in_pitch),
        .i_pitch_rate  (i_in_pitch_rate),
        .i_wheel_speed (i_in_wheel_speed),
        .i_period      (i_in_period),
        .i_out_stall   (i_out_stall),
        .o_status      (w_status),
        .o_out_valid   (o_out_valid),
        .o_torque      (o_out_torque)
    );

endmodule

`default_nettype wire

### rtl/bsf_checker.sv
// Port-level checker for the balance state-feedback controller, with its bind.
`default_nettype none

module bsf_checker
    import bsf_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire logic                   o_in_stall,
    input  wire logic                   i_in_kind,
    input  wire logic                   o_out_valid,
    input  wire logic                   i_out_stall,
    input  wire logic signed [IN_W-1:0] o_out_torque
);

    logic w_in_acc;

    assign w_in_acc = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_torque)))
        else $error("stalled result dropped or changed");

    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !i_in_kind) |=> o_in_stall)
        else $error("control request did not hold off the next request");

    a_clear_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_kind && !o_out_valid) |=> !o_out_valid)
        else $error("clear request produced a result");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a request in progress");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && (o_in_stall == !i_rst_n)))
        else $error("reset did not return to idle");

endmodule

bind balance_state_feedback bsf_checker u_bsf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_in_kind    (i_in_kind),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_out_torque (o_out_torque)
);

`default_nettype wire
